// ----- rtl/sit_pkg.sv -----
// Shared types and constants for the sorted insert table.
`default_nettype none

package sit_pkg;

    localparam int VALUE_W          = 32;
    localparam int POS_W            = 4;
    localparam int COUNT_W          = 5;
    localparam int OP_W             = 2;
    localparam int STATUS_W         = 2;
    localparam int DEFAULT_CAPACITY = 16;
    localparam int POS_SPAN         = 2 ** POS_W;
    localparam int S_TDATA_W        = 40;
    localparam int M_TDATA_W        = 40;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                      do_insert;
        logic                      do_remove;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/sit_cell.sv -----
// One storage cell of the sorted table chain.
`default_nettype none

module sit_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire                                aclk,
    input  sit_pkg::cell_ctrl_t                ctrl,
    input  wire  [CNT_W-1:0]                   count_in,
    input  wire                                left_place,
    input  wire  signed [sit_pkg::VALUE_W-1:0] left_value,
    input  wire  signed [sit_pkg::VALUE_W-1:0] right_value,
    output logic                               place_out,
    output logic signed [sit_pkg::VALUE_W-1:0] value_out
);
    import sit_pkg::*;

    localparam int IW = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [IW-1:0] IDX_V = IW'(IDX);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      occupied;
    logic                      at_or_after_pos;

    assign occupied        = IDX_V < IW'(count_in);
    assign at_or_after_pos = IDX_V >= IW'(ctrl.position);
    assign place_out       = !occupied || (value_reg > ctrl.value);
    assign value_out       = value_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl.do_insert) begin
            if (left_place) begin
                value_next = left_value;
            end else if (place_out) begin
                value_next = ctrl.value;
            end
        end else if (ctrl.do_remove && at_or_after_pos) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// ----- rtl/sorted_insert_table_unit.sv -----
// Top level of the sorted insert table: cell chain, count and result register.
//
//  Channel | Dir | tdata (low bit up)                        | tuser
//  s_      | in  | value[31:0], position[35:32], zero pad    | operation[1:0]
//  m_      | out | read_value[31:0], entry_count[36:32], pad | status[1:0]
//
// Each operation completes in the cycle it is accepted; all cells compare against the new
// value in parallel and shift toward their neighbor in the same cycle.
// A result appears in the cycle after its word is accepted, and a new word is
// accepted whenever the result register is empty or being taken.
// Reset clears the count and the result valid flag; cell contents are not reset.
`default_nettype none

module sorted_insert_table_unit #(
    parameter int CAPACITY = sit_pkg::DEFAULT_CAPACITY
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [sit_pkg::S_TDATA_W-1:0]   s_tdata,  // value, position
    input  wire  [sit_pkg::OP_W-1:0]        s_tuser,  // operation
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [sit_pkg::M_TDATA_W-1:0]   m_tdata,  // read_value, entry_count
    output logic [sit_pkg::STATUS_W-1:0]    m_tuser   // status
);
    import sit_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IW    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [COUNT_W-1:0]        out_count_reg;
    logic [STATUS_W-1:0]       out_status_reg;

    logic                      accept;
    logic [OP_W-1:0]           in_op;
    logic signed [VALUE_W-1:0] in_value;
    logic [POS_W-1:0]          in_pos;
    logic                      full;
    logic                      in_range;
    logic signed [VALUE_W-1:0] result_value;
    logic [STATUS_W-1:0]       result_status;
    cell_ctrl_t                ctrl;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic                      cell_place [CAPACITY];
    logic signed [VALUE_W-1:0] read_span  [POS_SPAN];

    assign in_op    = s_tuser;
    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_pos   = s_tdata[VALUE_W+POS_W-1:VALUE_W];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign full     = count_reg == CAP_V;
    assign in_range = IW'(in_pos) < IW'(count_reg);

    always_comb begin
        count_next     = count_reg;
        result_value   = '0;
        result_status  = ST_OK;
        ctrl.do_insert = 1'b0;
        ctrl.do_remove = 1'b0;
        ctrl.value     = in_value;
        ctrl.position  = in_pos;
        unique case (in_op)
            OP_INSERT: begin
                if (full) begin
                    result_status = ST_FULL;
                end else begin
                    ctrl.do_insert = accept;
                    count_next     = count_reg + CNT_W'(1);
                end
            end
            OP_READ: begin
                if (!in_range) begin
                    result_status = ST_RANGE;
                end else begin
                    result_value = read_span[in_pos];
                end
            end
            OP_REMOVE: begin
                if (!in_range) begin
                    result_status = ST_RANGE;
                end else begin
                    ctrl.do_remove = accept;
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    for (genvar j = 0; j < POS_SPAN; j++) begin : g_span
        if (j < CAPACITY) begin : g_used
            assign read_span[j] = cell_value[j];
        end else begin : g_unused
            assign read_span[j] = '0;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                      left_place;
        logic signed [VALUE_W-1:0] left_value;
        logic signed [VALUE_W-1:0] right_value;

        if (i == 0) begin : g_first
            assign left_place = 1'b0;
            assign left_value = '0;
        end else begin : g_inner
            assign left_place = cell_place[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[i];
        end else begin : g_notlast
            assign right_value = cell_value[i+1];
        end

        sit_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .count_in    (count_reg),
            .left_place  (left_place),
            .left_value  (left_value),
            .right_value (right_value),
            .place_out   (cell_place[i]),
            .value_out   (cell_value[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            count_reg     <= count_next;
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_value_reg  <= result_value;
            out_count_reg  <= COUNT_W'(count_next);
            out_status_reg <= result_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - COUNT_W){1'b0}}, out_count_reg, out_value_reg};
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_V)
        else $error("Stored count exceeds capacity.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_op == OP_INSERT && !full |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("Accepted insert did not grow the count.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg == ST_FULL |-> count_reg == CAP_V)
        else $error("Full status reported while table has room.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_value_reg != '0 |-> out_status_reg == ST_OK)
        else $error("Nonzero read value with an error status.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= CNT_W'(2) |-> cell_value[0] <= cell_value[1])
        else $error("First two entries out of order.");
`endif

endmodule

`default_nettype wire
